@@ rtl/core/skht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package skht_pkg;

    // Default sizes
    localparam int DEF_POOL_ENTRIES  = 64;
    localparam int DEF_BUCKETS       = 16;
    localparam int DEF_MAX_KEY_BYTES = 32;

    // Fixed field widths
    localparam int KEY_BYTES = 32;
    localparam int KEY_W     = KEY_BYTES * 8;
    localparam int LEN_W     = 6;
    localparam int PAY_W     = 32;

    // Opcodes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_BUCKET = 2'd3
    } opcode_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Hash unit status toward the controller
    typedef struct packed {
        logic busy;
        logic done;
    } hash_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/skht_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module skht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/skht_hash.sv @@
`timescale 1ns / 1ps
`default_nettype none

module skht_hash
    import skht_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [LEN_W-1:0]           len,
    input  wire logic [KEY_W-1:0]           key,
    output hash_stat_t                      stat,
    output logic      [$clog2(BUCKETS)-1:0] bucket_idx
);

    localparam int BW = $clog2(BUCKETS);
    // Reciprocal of the bucket count, exact quotient for any 32-bit hash
    localparam logic [63:0] RECIP = ((64'd1 << (32 + BW)) / 64'(BUCKETS)) + 64'd1;

    typedef enum logic [1:0] {
        H_IDLE,
        H_BYTES,
        H_MOD
    } hstate_t;

    hstate_t          state_reg;
    logic [31:0]      h_reg;
    logic [KEY_W-1:0] sh_reg;
    logic [LEN_W-1:0] cnt_reg;
    logic [64:0]      prod_reg;
    logic [BW-1:0]    rem_reg;
    logic             done_reg;

    logic [31:0]      h_next;
    logic [31:0]      quot;
    logic [31:0]      rem;

    // h*31 + byte
    assign h_next = (h_reg << 5) - h_reg + {24'd0, sh_reg[7:0]};

    // Remainder from the registered reciprocal product
    assign quot = 32'(prod_reg >> (32 + BW));
    assign rem  = h_reg - quot * 32'(BUCKETS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        h_reg     <= '0;
                        sh_reg    <= key;
                        cnt_reg   <= len;
                        state_reg <= H_BYTES;
                    end
                end
                H_BYTES:
                begin
                    if (cnt_reg == '0)
                    begin
                        prod_reg  <= 65'(h_reg) * 65'(RECIP[32:0]);
                        state_reg <= H_MOD;
                    end
                    else
                    begin
                        h_reg   <= h_next;
                        sh_reg  <= sh_reg >> 8;
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                H_MOD:
                begin
                    rem_reg   <= rem[BW-1:0];
                    done_reg  <= 1'b1;
                    state_reg <= H_IDLE;
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    assign stat.busy  = (state_reg != H_IDLE);
    assign stat.done  = done_reg;
    assign bucket_idx = rem_reg;

endmodule

`default_nettype wire

@@ rtl/core/string_key_hash_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Steps: the byte-serial key hash gives the bucket, the bucket head is read, each chain
//   entry visited is read and compared, an insert is linked and S_OUT registers the result.
// The free-entry scan visits one pool entry a cycle and may add wait on insert.
// Throughput: one item at a time; the byte-serial hash and the chain walk
//   through the entry memories set the figure.
// Reset: asynchronous, active low; clears control, bucket valid and pool flags.

module string_key_hash_table_unit
    import skht_pkg::*;
#(
    parameter int POOL_ENTRIES  = DEF_POOL_ENTRIES,
    parameter int BUCKETS       = DEF_BUCKETS,
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // key_length[5:0], key_word0..3[261:6], age[293:262], weight_bits[325:294]
    input  wire logic [327:0] s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // bucket[3:0], out_age[35:4], out_weight_bits[67:36]
    output logic [71:0]       m_tdata,
    // status[1:0]
    output logic [1:0]        m_tuser
);

    localparam int IW  = $clog2(POOL_ENTRIES);
    localparam int BW  = $clog2(BUCKETS);
    localparam int SW  = $clog2(POOL_ENTRIES + 1);
    localparam int KRW = KEY_W + LEN_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_FREE,
        S_HEAD,
        S_START,
        S_RD,
        S_CMP,
        S_INS1,
        S_INS2,
        S_INS3,
        S_OUT
    } state_t;

    state_t             state_reg;
    opcode_t            op_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [2*PAY_W-1:0] pay_reg;
    logic [2*PAY_W-1:0] res_pay_reg;
    status_t            res_status_reg;
    logic [BW-1:0]      bucket_reg;
    logic [IW-1:0]      head_reg;
    logic [IW-1:0]      cur_reg;
    logic [IW-1:0]      tail_reg;
    logic [IW-1:0]      steps_reg;
    logic [BUCKETS-1:0] hvalid_reg;
    logic [POOL_ENTRIES-1:0] in_use_reg;
    logic               m_tvalid_reg;
    logic [71:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    // free-entry scan
    logic               scan_busy_reg;
    logic               free_found_reg;
    logic [SW-1:0]      scan_reg;
    logic [IW-1:0]      free_reg;

    // input decode
    logic [LEN_W-1:0]   len_clamp;
    logic [KEY_W-1:0]   key_masked;
    logic               accept;

    // hash unit
    hash_stat_t         hstat;
    logic [BW-1:0]      hash_bucket;

    // memories
    logic [KRW-1:0]     key_rd;
    logic [2*PAY_W-1:0] pay_rd;
    logic [IW-1:0]      next_rd;
    logic [IW-1:0]      prev_rd;
    logic [IW-1:0]      head_rd;
    logic               head_we;
    logic [IW-1:0]      head_wdata;
    logic               next_we;
    logic [IW-1:0]      next_waddr;
    logic [IW-1:0]      next_wdata;
    logic               prev_we;
    logic [IW-1:0]      prev_waddr;
    logic [IW-1:0]      prev_wdata;
    logic [IW-1:0]      prev_raddr;
    logic               ins_we;

    // walk decode
    logic               hv;
    logic               match;
    logic               rm_found;
    logic               rm_multi;
    logic [31:0]        bucket32;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Clamp length and clear bytes past it
    always_comb
    begin
        if (s_tdata[LEN_W-1:0] > LEN_W'(MAX_KEY_BYTES))
        begin
            len_clamp = LEN_W'(MAX_KEY_BYTES);
        end
        else
        begin
            len_clamp = s_tdata[LEN_W-1:0];
        end
        for (int j = 0; j < KEY_BYTES; j++)
        begin
            if (LEN_W'(j) < len_clamp)
            begin
                key_masked[j*8 +: 8] = s_tdata[LEN_W + j*8 +: 8];
            end
            else
            begin
                key_masked[j*8 +: 8] = 8'd0;
            end
        end
    end

    skht_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .len        (len_clamp),
        .key        (key_masked),
        .stat       (hstat),
        .bucket_idx (hash_bucket)
    );

    // Walk and update decode
    assign hv       = hvalid_reg[bucket_reg];
    assign match    = in_use_reg[cur_reg] && (key_rd == {len_reg, key_reg});
    assign rm_found = (state_reg == S_CMP) && match && (op_reg == OP_REMOVE);
    assign rm_multi = rm_found && (next_rd != cur_reg);
    assign ins_we   = (state_reg == S_INS1);

    always_comb
    begin
        head_we    = ins_we || (rm_multi && (head_reg == cur_reg));
        head_wdata = ins_we ? free_reg : next_rd;
        prev_raddr = ins_we ? head_reg : cur_reg;

        next_we    = 1'b0;
        next_waddr = free_reg;
        next_wdata = free_reg;
        prev_we    = 1'b0;
        prev_waddr = free_reg;
        prev_wdata = free_reg;
        case (state_reg)
            S_INS1:
            begin
                // first entry of the chain links to itself
                next_we = !hv;
                prev_we = !hv;
            end
            S_INS2:
            begin
                next_we    = 1'b1;
                next_wdata = head_reg;
                prev_we    = 1'b1;
                prev_wdata = prev_rd;
            end
            S_INS3:
            begin
                next_we    = 1'b1;
                next_waddr = tail_reg;
                prev_we    = 1'b1;
                prev_waddr = head_reg;
            end
            S_CMP:
            begin
                // unlink: next[p] = n, prev[n] = p
                next_we    = rm_multi;
                next_waddr = prev_rd;
                next_wdata = next_rd;
                prev_we    = rm_multi;
                prev_waddr = next_rd;
                prev_wdata = prev_rd;
            end
            default:
            begin
                next_we = 1'b0;
                prev_we = 1'b0;
            end
        endcase
    end

    skht_ram #(.WIDTH(KRW), .DEPTH(POOL_ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (ins_we),
        .waddr (free_reg),
        .wdata ({len_reg, key_reg}),
        .raddr (cur_reg),
        .rdata (key_rd)
    );

    skht_ram #(.WIDTH(2*PAY_W), .DEPTH(POOL_ENTRIES)) u_pay_ram (
        .clk   (clk),
        .we    (ins_we),
        .waddr (free_reg),
        .wdata (pay_reg),
        .raddr (cur_reg),
        .rdata (pay_rd)
    );

    skht_ram #(.WIDTH(IW), .DEPTH(POOL_ENTRIES)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (cur_reg),
        .rdata (next_rd)
    );

    skht_ram #(.WIDTH(IW), .DEPTH(POOL_ENTRIES)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (prev_raddr),
        .rdata (prev_rd)
    );

    skht_ram #(.WIDTH(IW), .DEPTH(BUCKETS)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (bucket_reg),
        .wdata (head_wdata),
        .raddr (bucket_reg),
        .rdata (head_rd)
    );

    // Lowest free entry, one pool flag a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_busy_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            scan_reg       <= '0;
        end
        else if (accept)
        begin
            scan_busy_reg  <= 1'b1;
            free_found_reg <= 1'b0;
            scan_reg       <= '0;
        end
        else if (scan_busy_reg)
        begin
            if (!in_use_reg[scan_reg[IW-1:0]])
            begin
                free_found_reg <= 1'b1;
                free_reg       <= scan_reg[IW-1:0];
                scan_busy_reg  <= 1'b0;
            end
            else if (scan_reg == SW'(POOL_ENTRIES - 1))
            begin
                scan_busy_reg <= 1'b0;
            end
            else
            begin
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    assign bucket32 = 32'(bucket_reg);

    // Controller
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            hvalid_reg   <= '0;
            in_use_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // result taken; a new one loaded in S_OUT takes its place
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg      <= opcode_t'(s_tuser);
                        len_reg     <= len_clamp;
                        key_reg     <= key_masked;
                        pay_reg     <= s_tdata[LEN_W + KEY_W +: 2*PAY_W];
                        res_pay_reg <= '0;
                        state_reg   <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (hstat.done)
                    begin
                        bucket_reg <= hash_bucket;
                        case (op_reg)
                            OP_BUCKET:
                            begin
                                res_status_reg <= ST_DONE;
                                state_reg      <= S_OUT;
                            end
                            OP_INSERT:
                            begin
                                state_reg <= S_FREE;
                            end
                            default:
                            begin
                                state_reg <= S_HEAD;
                            end
                        endcase
                    end
                end
                S_FREE:
                begin
                    if (!scan_busy_reg)
                    begin
                        if (free_found_reg)
                        begin
                            state_reg <= S_HEAD;
                        end
                        else
                        begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_OUT;
                        end
                    end
                end
                S_HEAD:
                begin
                    state_reg <= S_START;
                end
                S_START:
                begin
                    if (hv)
                    begin
                        head_reg  <= head_rd;
                        cur_reg   <= head_rd;
                        steps_reg <= '0;
                        state_reg <= S_RD;
                    end
                    else if (op_reg == OP_INSERT)
                    begin
                        state_reg <= S_INS1;
                    end
                    else
                    begin
                        res_status_reg <= ST_NOTFOUND;
                        state_reg      <= S_OUT;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (match)
                    begin
                        case (op_reg)
                            OP_LOOKUP:
                            begin
                                res_pay_reg    <= pay_rd;
                                res_status_reg <= ST_DONE;
                            end
                            OP_REMOVE:
                            begin
                                if (!rm_multi)
                                begin
                                    hvalid_reg[bucket_reg] <= 1'b0;
                                end
                                in_use_reg[cur_reg] <= 1'b0;
                                res_status_reg      <= ST_DONE;
                            end
                            default:
                            begin
                                res_status_reg <= ST_PRESENT;
                            end
                        endcase
                        state_reg <= S_OUT;
                    end
                    else if (!in_use_reg[cur_reg] || (next_rd == head_reg) ||
                             (steps_reg == IW'(POOL_ENTRIES - 1)))
                    begin
                        // end of chain without a match
                        if (op_reg == OP_INSERT)
                        begin
                            state_reg <= S_INS1;
                        end
                        else
                        begin
                            res_status_reg <= ST_NOTFOUND;
                            state_reg      <= S_OUT;
                        end
                    end
                    else
                    begin
                        cur_reg   <= next_rd;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_INS1:
                begin
                    in_use_reg[free_reg]   <= 1'b1;
                    hvalid_reg[bucket_reg] <= 1'b1;
                    if (hv)
                    begin
                        state_reg <= S_INS2;
                    end
                    else
                    begin
                        res_status_reg <= ST_DONE;
                        state_reg      <= S_OUT;
                    end
                end
                S_INS2:
                begin
                    tail_reg  <= prev_rd;
                    state_reg <= S_INS3;
                end
                S_INS3:
                begin
                    res_status_reg <= ST_DONE;
                    state_reg      <= S_OUT;
                end
                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status_reg;
                        m_tdata_reg  <= {4'd0, res_pay_reg, bucket32[3:0]};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

@@ rtl/core/skht_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module skht_checker
    import skht_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [327:0] s_tdata,
    input wire logic [1:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [71:0]  m_tdata,
    input wire logic [1:0]   m_tuser
);

    // No result is shown while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // One item at a time: input closes after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input open right after a transfer");

    // A new result appears only from a busy block
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without an item in work");

    // Payload fields are zero unless the status is done (only a lookup hit loads them)
    a_pay_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_DONE) |-> (m_tdata[71:4] == '0))
        else $error("payload nonzero on a miss");

endmodule

bind string_key_hash_table_unit skht_checker u_skht_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import skht_pkg::*;

    localparam int POOL    = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  bucket;
        logic [31:0] age;
        logic [31:0] weight;
    } table_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [327:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic [1:0]   m_tuser;

    string_key_hash_table_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Predicted table contents
    logic [255:0] slot_key [POOL];
    logic [5:0]   slot_len [POOL];
    logic [31:0]  slot_age [POOL];
    logic [31:0]  slot_wt  [POOL];
    logic         slot_used [POOL];

    table_result_t pending_results[$];
    int  mismatches;
    int  idle_pct_tx;
    int  idle_pct_rx;
    bit  rx_hold;
    int  quiet_cycles;

    // Small set of keys so inserts, removes and lookups collide
    logic [255:0] key_bank [24];
    logic [5:0]   len_bank [24];

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [255:0] mask_key(logic [255:0] raw, int len);
        logic [255:0] m;
        m = '0;
        for (int i = 0; i < len; i++)
        begin
            m[i*8 +: 8] = raw[i*8 +: 8];
        end
        return m;
    endfunction

    function automatic logic [3:0] string_bucket(logic [255:0] k, int len);
        logic [31:0] h;
        h = 32'd0;
        for (int i = 0; i < len; i++)
        begin
            h = h * 32'd31 + {24'd0, k[i*8 +: 8]};
        end
        return h[3:0];
    endfunction

    // Table behavior; chain order does not affect results, so a flat pool with
    // key search over used slots gives the same answers.
    function automatic table_result_t predict_table(opcode_t op, logic [5:0] raw_len,
                                                    logic [255:0] raw_key,
                                                    logic [31:0] age, logic [31:0] wt);
        table_result_t r;
        int len;
        int hit;
        int free_slot;
        logic [255:0] k;
        len = (raw_len > 6'd32) ? 32 : int'(raw_len);
        k = mask_key(raw_key, len);
        r = '0;
        r.bucket = string_bucket(k, len);
        hit = -1;
        free_slot = -1;
        for (int e = 0; e < POOL; e++)
        begin
            if (slot_used[e] && slot_len[e] == len[5:0] && slot_key[e] == k)
            begin
                hit = e;
            end
            if (!slot_used[e] && free_slot < 0)
            begin
                free_slot = e;
            end
        end
        case (op)
            OP_INSERT:
            begin
                if (free_slot < 0)
                begin
                    r.status = ST_FULL;
                end
                else if (hit >= 0)
                begin
                    r.status = ST_PRESENT;
                end
                else
                begin
                    slot_used[free_slot] = 1'b1;
                    slot_key[free_slot]  = k;
                    slot_len[free_slot]  = len[5:0];
                    slot_age[free_slot]  = age;
                    slot_wt[free_slot]   = wt;
                    r.status = ST_DONE;
                end
            end
            OP_REMOVE:
            begin
                if (hit < 0)
                begin
                    r.status = ST_NOTFOUND;
                end
                else
                begin
                    slot_used[hit] = 1'b0;
                    r.status = ST_DONE;
                end
            end
            OP_LOOKUP:
            begin
                if (hit < 0)
                begin
                    r.status = ST_NOTFOUND;
                end
                else
                begin
                    r.status = ST_DONE;
                    r.age    = slot_age[hit];
                    r.weight = slot_wt[hit];
                end
            end
            default:
            begin
                r.status = ST_DONE;
            end
        endcase
        return r;
    endfunction

    function automatic int used_count();
        int n;
        n = 0;
        for (int e = 0; e < POOL; e++)
        begin
            n += slot_used[e];
        end
        return n;
    endfunction

    // Send one item and queue its expected result
    task automatic send_item(opcode_t op, logic [5:0] len, logic [255:0] key,
                             logic [31:0] age, logic [31:0] wt);
        while (idle_pct_tx > 0 && $urandom_range(99, 0) < idle_pct_tx)
        begin
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {2'b00, wt, age, key, len};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        pending_results.push_back(predict_table(op, len, key, age, wt));
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [255:0] random_key();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic send_bank(opcode_t op, int idx);
        send_item(op, len_bank[idx], key_bank[idx], $urandom, $urandom);
    endtask

    // Directed: extremes of the key, every operation, duplicates, misses
    task automatic test_directed();
        logic [255:0] ones;
        ones = '1;
        send_item(OP_BUCKET, 6'd0, ones, '1, '1);
        send_item(OP_INSERT, 6'd0, ones, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_INSERT, 6'd0, '0, 32'h1, 32'h2);
        send_item(OP_LOOKUP, 6'd0, 256'h5, '0, '0);
        send_item(OP_INSERT, 6'd63, ones, 32'h0, 32'hFFFF_FFFF);
        send_item(OP_LOOKUP, 6'd32, ones, '0, '0);
        send_item(OP_LOOKUP, 6'd40, ones, '0, '0);
        send_item(OP_BUCKET, 6'd32, ones, '0, '0);
        send_item(OP_LOOKUP, 6'd31, ones, '0, '0);
        send_item(OP_INSERT, 6'd1, 256'h41, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_item(OP_INSERT, 6'd1, 256'hFF41, 32'h3, 32'h4);
        send_item(OP_LOOKUP, 6'd1, 256'h41, '0, '0);
        send_item(OP_REMOVE, 6'd1, 256'h41, '0, '0);
        send_item(OP_REMOVE, 6'd1, 256'h41, '0, '0);
        send_item(OP_LOOKUP, 6'd1, 256'h41, '0, '0);
        send_item(OP_REMOVE, 6'd0, '0, '0, '0);
        send_item(OP_REMOVE, 6'd32, ones, '0, '0);
        send_item(OP_BUCKET, 6'd8, 256'h0102_0304_0506_0708, '0, '0);
        send_item(OP_BUCKET, 6'd17, random_key(), '0, '0);
        wait_drained();
    endtask

    // Fill the pool, probe full behavior with a present key, then empty it
    task automatic test_pool_full();
        while (used_count() < POOL)
        begin
            send_item(OP_INSERT, 6'($urandom_range(32, 1)), random_key(), $urandom, $urandom);
        end
        send_item(OP_INSERT, 6'd5, random_key(), $urandom, $urandom);
        for (int e = 0; e < POOL; e++)
        begin
            if (slot_used[e])
            begin
                send_item(OP_INSERT, slot_len[e], slot_key[e], $urandom, $urandom);
                break;
            end
        end
        for (int e = 0; e < POOL; e++)
        begin
            if (slot_used[e])
            begin
                send_item(OP_LOOKUP, slot_len[e], slot_key[e] | ~mask_key('1, slot_len[e]),
                          '0, '0);
                send_item(OP_REMOVE, slot_len[e], slot_key[e], '0, '0);
            end
        end
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1'b1;
                repeat (600) @(negedge clk);
                rx_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 20; i++)
                begin
                    send_bank(opcode_t'($urandom_range(3, 0)), $urandom_range(23, 0));
                end
            end
        join
        wait_drained();
    endtask

    // Random mix over a small key bank, with some fully random keys
    task automatic test_random(int count, int tx_pct, int rx_pct);
        idle_pct_tx = tx_pct;
        idle_pct_rx = rx_pct;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9, 0) == 0)
            begin
                send_item(opcode_t'($urandom_range(3, 0)), 6'($urandom), random_key(),
                          $urandom, $urandom);
            end
            else
            begin
                send_bank(opcode_t'($urandom_range(3, 0)), $urandom_range(23, 0));
            end
        end
        wait_drained();
    endtask

    // Result checker
    always @(posedge clk)
    begin
        table_result_t got;
        table_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[3:0], m_tdata[35:4], m_tdata[67:36]};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result %h", got);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.bucket !== want.bucket ||
                    got.age !== want.age || got.weight !== want.weight)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: status %0d/%0d bucket %0d/%0d age %h/%h wt %h/%h",
                                 want.status, got.status, want.bucket, got.bucket,
                                 want.age, got.age, want.weight, got.weight);
                    end
                end
            end
        end
    end

    // Receiver ready
    always @(negedge clk)
    begin
        m_tready <= !rx_hold && !(idle_pct_rx > 0 && $urandom_range(99, 0) < idle_pct_rx);
    end

    // Watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_INSERT;
        m_tready = 1'b0;
        rx_hold = 1'b0;
        quiet_cycles = 0;
        mismatches = 0;
        idle_pct_tx = 32;
        idle_pct_rx = 32;
        for (int e = 0; e < POOL; e++)
        begin
            slot_used[e] = 1'b0;
        end
        for (int i = 0; i < 24; i++)
        begin
            len_bank[i] = 6'($urandom_range(32, 0));
            key_bank[i] = mask_key(random_key(), len_bank[i]);
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_pool_full();
        test_backpressure();
        test_random(400, 32, 32);
        test_random(300, 0, 0);
        test_random(300, 32, 32);

        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
